FILE: src/skeleton_global_pose_unit_assert.svh
// assertion macros for the global pose unit
`ifndef SKELETON_GLOBAL_POSE_UNIT_ASSERT_SVH
`define SKELETON_GLOBAL_POSE_UNIT_ASSERT_SVH
`define SGP_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define SGP_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: src/sgp_pkg.sv
// ----------------------------------------------------------------------------
// sgp_pkg
// shared constants, types and a rounding right shift of the global pose unit
// ----------------------------------------------------------------------------
`default_nettype none
package sgp_pkg;
  localparam int MAX_NODES_DEF = 256;
  localparam int MAX_BONES_DEF = 256;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NODE = 1'b1;
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } pose_t;

  function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int sh);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction
endpackage
`default_nettype wire

FILE: src/sgp_divsqrt.sv
// ----------------------------------------------------------------------------
// sgp_divsqrt
// bit-serial integer square root and truncating quotient unit
// ----------------------------------------------------------------------------
`default_nettype none
module sgp_divsqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        sq_start,
  input  wire logic [63:0] sq_n,
  input  wire logic        dv_start,
  input  wire logic [63:0] dv_num,
  input  wire logic [63:0] dv_den,
  output logic             done,
  output logic [63:0]      result
);
  logic [63:0] rem_r, rem_nxt, res_r, res_nxt, bit_r, bit_nxt, den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        sq_r, sq_nxt, run_r, run_nxt, done_nxt;
  logic [64:0] trial;

  always_comb begin
    rem_nxt = rem_r; res_nxt = res_r; bit_nxt = bit_r; cnt_nxt = cnt_r;
    sq_nxt = sq_r; run_nxt = run_r; done_nxt = 1'b0; trial = '0;
    if (sq_start) begin
      rem_nxt = sq_n; res_nxt = '0; bit_nxt = 64'd1 << 62; cnt_nxt = 7'd32;
      sq_nxt = 1'b1; run_nxt = 1'b1;
    end else if (dv_start) begin
      rem_nxt = '0; res_nxt = dv_num; cnt_nxt = 7'd64; sq_nxt = 1'b0; run_nxt = 1'b1;
    end else if (run_r) begin
      if (sq_r) begin
        if (rem_r >= res_r + bit_r) begin
          rem_nxt = rem_r - (res_r + bit_r);
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end else begin
        trial = {rem_r, res_r[63]};
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = 64'(trial - {1'b0, den_r});
          res_nxt = {res_r[62:0], 1'b1};
        end else begin
          rem_nxt = trial[63:0];
          res_nxt = {res_r[62:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        run_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; done <= 1'b0; sq_r <= 1'b0; cnt_r <= '0;
    end else begin
      run_r <= run_nxt; done <= done_nxt; sq_r <= sq_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; res_r <= res_nxt; bit_r <= bit_nxt;
    if (dv_start) den_r <= dv_den;
  end

  assign result = res_r;
endmodule
`default_nettype wire

FILE: src/skeleton_global_pose_unit.sv
// ----------------------------------------------------------------------------
// skeleton_global_pose_unit
// forward kinematics over a skeleton hierarchy, poses held in memories
// ----------------------------------------------------------------------------
// load beat: accepted in S_IDLE, then passes S_WR; root node: S_IDLE, S_RD, S_WR
// child node: most of its time goes to the 32-step square root and four 64-step
// divisions, which are skipped when the parent quaternion is zero
// result strobes in the cycle after a node with a valid bone finishes; the receiver cannot stall
// synchronous active-low reset clears control only; memories are not cleared
`default_nettype none
module skeleton_global_pose_unit #(
  parameter int MAX_NODES = sgp_pkg::MAX_NODES_DEF,
  parameter int MAX_BONES = sgp_pkg::MAX_BONES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_operation,
  input  wire logic [7:0]         in_index,
  input  wire logic signed [8:0]  in_parent_index,
  input  wire logic signed [8:0]  in_bone_index,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [15:0] in_quat_w,
  input  wire logic signed [15:0] in_quat_x,
  input  wire logic signed [15:0] in_quat_y,
  input  wire logic signed [15:0] in_quat_z,
  output logic                    out_valid,
  output logic [7:0]              out_bone,
  output logic signed [31:0]      out_global_x,
  output logic signed [31:0]      out_global_y,
  output logic signed [31:0]      out_global_z,
  output logic signed [15:0]      out_global_qw,
  output logic signed [15:0]      out_global_qx,
  output logic signed [15:0]      out_global_qy,
  output logic signed [15:0]      out_global_qz,
  output logic                    out_saturated
);
  // indexes are 8 bits wide, so no more than 256 entries are reachable
  localparam int ND = (MAX_NODES < 256) ? MAX_NODES : 256;
  localparam int BD = (MAX_BONES < 256) ? MAX_BONES : 256;
  localparam int NW = (ND > 1) ? $clog2(ND) : 1;
  localparam int BW = (BD > 1) ? $clog2(BD) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_NORM, S_SQ, S_DIV, S_CR1, S_T, S_CR2, S_SUM, S_QP, S_WR
  } state_t;

  sgp_pkg::pose_t bone_mem [BD];
  sgp_pkg::pose_t node_mem [ND];
  sgp_pkg::pose_t lp_rd, pp_rd, rest_r, gp_r;

  state_t state_r;
  logic [7:0] idx_r, bone_r;
  logic root_r, hasb_r, store_r, flag_r;
  logic [63:0] n2_r, s_r;
  logic signed [31:0] un_r [4];
  logic signed [63:0] c_r [3];
  logic signed [35:0] t_r [3];
  logic signed [63:0] wt_r [3];
  logic signed [63:0] m_r [4];
  logic [1:0] k_r, dk;
  logic [3:0] qk_r;
  logic sq_go, dv_go, ds_done;
  logic [63:0] dv_num, dv_den, ds_res, pmag;
  logic signed [63:0] pq_ext;
  logic signed [31:0] lpv [3], ppv [3];
  logic signed [15:0] lqv [4], pqv [4];
  logic signed [63:0] rsum, prod;
  logic signed [31:0] pval_sel;
  logic in_parent_ok, in_bone_ok;

  assign in_parent_ok = !in_parent_index[8] && (32'(in_parent_index) < MAX_NODES);
  assign in_bone_ok   = !in_bone_index[8] && (32'(in_bone_index) < MAX_BONES);

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      if (in_operation == sgp_pkg::OP_LOAD && 32'(in_index) < MAX_BONES)
        bone_mem[in_index[BW-1:0]] <= {in_pos_x, in_pos_y, in_pos_z,
                                       in_quat_w, in_quat_x, in_quat_y, in_quat_z};
      lp_rd <= bone_mem[in_bone_index[BW-1:0]];
      pp_rd <= node_mem[in_parent_index[NW-1:0]];
    end
    if (state_r == S_WR && store_r) node_mem[idx_r[NW-1:0]] <= gp_r;
  end

  always_comb begin
    lpv[0] = hasb_r ? lp_rd.x : rest_r.x;
    lpv[1] = hasb_r ? lp_rd.y : rest_r.y;
    lpv[2] = hasb_r ? lp_rd.z : rest_r.z;
    lqv[0] = hasb_r ? lp_rd.qw : rest_r.qw;
    lqv[1] = hasb_r ? lp_rd.qx : rest_r.qx;
    lqv[2] = hasb_r ? lp_rd.qy : rest_r.qy;
    lqv[3] = hasb_r ? lp_rd.qz : rest_r.qz;
    ppv[0] = pp_rd.x; ppv[1] = pp_rd.y; ppv[2] = pp_rd.z;
    pqv[0] = pp_rd.qw; pqv[1] = pp_rd.qx;
    pqv[2] = pp_rd.qy; pqv[3] = pp_rd.qz;
  end

  // part being divided: the next one while a division finishes
  assign dk = (state_r == S_DIV) ? k_r + 2'd1 : k_r;
  assign pq_ext = 64'(pqv[dk]) <<< 43;
  assign pmag = pqv[dk][15] ? 64'(-pq_ext) : 64'(pq_ext);
  assign sq_go = (state_r == S_NORM) && n2_r != 64'd0;
  assign dv_go = (state_r == S_SQ && ds_done) || (state_r == S_DIV && ds_done && k_r != 2'd3);
  assign dv_num = pmag + ((state_r == S_SQ ? ds_res : s_r) >> 1);
  assign dv_den = (state_r == S_SQ) ? ds_res : s_r;

  sgp_divsqrt u_ds (
    .clk(clk), .rst_n(rst_n), .sq_start(sq_go), .sq_n(n2_r << 30),
    .dv_start(dv_go), .dv_num(dv_num), .dv_den(dv_den), .done(ds_done), .result(ds_res)
  );

  // one product term of the quaternion product per cycle
  always_comb begin
    logic signed [15:0] a, b;
    logic neg;
    a = '0; b = '0; neg = 1'b0;
    unique case (qk_r)
      4'd0:  begin a = pqv[0][15:0]; b = lqv[0][15:0]; end
      4'd1:  begin a = pqv[1][15:0]; b = lqv[1][15:0]; neg = 1'b1; end
      4'd2:  begin a = pqv[2][15:0]; b = lqv[2][15:0]; neg = 1'b1; end
      4'd3:  begin a = pqv[3][15:0]; b = lqv[3][15:0]; neg = 1'b1; end
      4'd4:  begin a = pqv[0][15:0]; b = lqv[1][15:0]; end
      4'd5:  begin a = pqv[1][15:0]; b = lqv[0][15:0]; end
      4'd6:  begin a = pqv[2][15:0]; b = lqv[3][15:0]; end
      4'd7:  begin a = pqv[3][15:0]; b = lqv[2][15:0]; neg = 1'b1; end
      4'd8:  begin a = pqv[0][15:0]; b = lqv[2][15:0]; end
      4'd9:  begin a = pqv[1][15:0]; b = lqv[3][15:0]; neg = 1'b1; end
      4'd10: begin a = pqv[2][15:0]; b = lqv[0][15:0]; end
      4'd11: begin a = pqv[3][15:0]; b = lqv[1][15:0]; end
      4'd12: begin a = pqv[0][15:0]; b = lqv[3][15:0]; end
      4'd13: begin a = pqv[1][15:0]; b = lqv[2][15:0]; end
      4'd14: begin a = pqv[2][15:0]; b = lqv[1][15:0]; neg = 1'b1; end
      default: begin a = pqv[3][15:0]; b = lqv[0][15:0]; end
    endcase
    prod = 64'(a * b);
    if (neg) prod = -prod;
  end

  always_comb begin
    rsum = 64'(lpv[k_r]) + wt_r[k_r] + sgp_pkg::rshr(c_r[k_r], 28) + 64'(ppv[k_r]);
    pval_sel = rsum[31:0];
  end

  function automatic logic signed [63:0] xcomp(input logic [1:0] i,
      input logic signed [31:0] a0, a1, a2, input logic signed [35:0] b0, b1, b2);
    unique case (i)
      2'd0:    return 64'(a1 * b2) - 64'(a2 * b1);
      2'd1:    return 64'(a2 * b0) - 64'(a0 * b2);
      default: return 64'(a0 * b1) - 64'(a1 * b0);
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; busy <= 1'b0; out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          busy <= 1'b1;
          idx_r <= in_index; bone_r <= in_bone_index[7:0];
          hasb_r <= (in_operation == sgp_pkg::OP_NODE) && in_bone_ok;
          root_r <= !in_parent_ok;
          rest_r <= {in_pos_x, in_pos_y, in_pos_z, in_quat_w, in_quat_x, in_quat_y, in_quat_z};
          flag_r <= 1'b0; k_r <= '0; qk_r <= '0;
          state_r <= (in_operation == sgp_pkg::OP_LOAD) ? S_WR : S_RD;
          store_r <= (in_operation == sgp_pkg::OP_NODE) && (32'(in_index) < MAX_NODES);
        end
        S_RD: begin
          if (root_r) begin
            gp_r <= rest_r; state_r <= S_WR;
          end else begin
            n2_r <= 64'(pqv[0] * pqv[0]) + 64'(pqv[1] * pqv[1])
                  + 64'(pqv[2] * pqv[2]) + 64'(pqv[3] * pqv[3]);
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (n2_r == 64'd0) begin
            for (int i = 0; i < 4; i++) un_r[i] <= '0;
            state_r <= S_CR1;
          end else state_r <= S_SQ;
        end
        S_SQ: if (ds_done) begin s_r <= ds_res; state_r <= S_DIV; end
        S_DIV: if (ds_done) begin
          un_r[k_r] <= pqv[k_r][15] ? -$signed(ds_res[31:0]) : $signed(ds_res[31:0]);
          k_r <= k_r + 2'd1;
          if (k_r == 2'd3) state_r <= S_CR1;
        end
        S_CR1: begin
          for (int i = 0; i < 3; i++)
            c_r[i] <= xcomp(2'(i), un_r[1], un_r[2], un_r[3],
                            36'(lpv[0]), 36'(lpv[1]), 36'(lpv[2]));
          state_r <= S_T;
        end
        S_T: begin
          for (int i = 0; i < 3; i++) t_r[i] <= 36'(sgp_pkg::rshr(c_r[i] <<< 1, 28));
          state_r <= S_CR2;
        end
        S_CR2: begin
          for (int i = 0; i < 3; i++) begin
            c_r[i] <= xcomp(2'(i), un_r[1], un_r[2], un_r[3], t_r[0], t_r[1], t_r[2]);
            wt_r[i] <= sgp_pkg::rshr(64'(un_r[0] * t_r[i]), 28);
          end
          k_r <= '0; state_r <= S_SUM;
        end
        S_SUM: begin
          logic signed [31:0] v;
          v = pval_sel;
          if (rsum > 64'sd2147483647) begin v = 32'h7fffffff; flag_r <= 1'b1; end
          else if (rsum < -64'sd2147483648) begin v = 32'h80000000; flag_r <= 1'b1; end
          unique case (k_r)
            2'd0:    gp_r.x <= v;
            2'd1:    gp_r.y <= v;
            default: gp_r.z <= v;
          endcase
          k_r <= k_r + 2'd1;
          if (k_r == 2'd2) begin
            for (int i = 0; i < 4; i++) m_r[i] <= '0;
            qk_r <= '0; state_r <= S_QP;
          end
        end
        S_QP: begin
          logic signed [63:0] acc, rr;
          logic signed [15:0] qv;
          logic fl;
          acc = m_r[qk_r[3:2]] + prod;
          m_r[qk_r[3:2]] <= acc;
          rr = sgp_pkg::rshr(acc, 14);
          qv = rr[15:0]; fl = 1'b0;
          if (rr > 64'sd32767) begin qv = 16'h7fff; fl = 1'b1; end
          else if (rr < -64'sd32768) begin qv = 16'h8000; fl = 1'b1; end
          if (qk_r[1:0] == 2'd3) begin
            if (fl) flag_r <= 1'b1;
            unique case (qk_r[3:2])
              2'd0:    gp_r.qw <= qv;
              2'd1:    gp_r.qx <= qv;
              2'd2:    gp_r.qy <= qv;
              default: gp_r.qz <= qv;
            endcase
          end
          qk_r <= qk_r + 4'd1;
          if (qk_r == 4'd15) state_r <= S_WR;
        end
        S_WR: begin
          busy <= 1'b0; state_r <= S_IDLE;
          if (hasb_r) out_valid <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (state_r == S_WR) begin
      out_bone <= bone_r;
      out_global_x <= gp_r.x; out_global_y <= gp_r.y; out_global_z <= gp_r.z;
      out_global_qw <= gp_r.qw; out_global_qx <= gp_r.qx;
      out_global_qy <= gp_r.qy; out_global_qz <= gp_r.qz;
      out_saturated <= flag_r;
    end
  end
endmodule
`default_nettype wire

FILE: src/sgp_checker.sv
// ----------------------------------------------------------------------------
// sgp_checker
// port-level checks of the global pose unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "skeleton_global_pose_unit_assert.svh"
module sgp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);
  `SGP_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
  `SGP_ASSERT_IMPL(a_strobe_busy, clk, rst_n, out_valid, !busy)
  `SGP_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
endmodule
bind skeleton_global_pose_unit sgp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);
`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the skeleton global pose unit. It loads bone poses and
// builds hierarchies with root and child nodes. Each accepted beat goes
// through an in-bench fixed-point pose calculator, and every output strobe
// is checked against the oldest predicted pose.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic              op;
    logic [7:0]        index;
    logic signed [8:0] parent;
    logic signed [8:0] bone;
    logic signed [31:0] p [3];
    logic signed [15:0] q [4];
  } beat_t;

  typedef struct packed {
    logic [7:0]      bone;
    sgp_pkg::pose_t  pose;
    logic            sat;
  } pose_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = 1'b0;
  logic [7:0] in_index = '0;
  logic signed [8:0] in_parent_index = '0;
  logic signed [8:0] in_bone_index = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_valid;
  logic [7:0] out_bone;
  logic signed [31:0] out_global_x, out_global_y, out_global_z;
  logic signed [15:0] out_global_qw, out_global_qx, out_global_qy, out_global_qz;
  logic out_saturated;

  skeleton_global_pose_unit dut (.*);

  beat_t pending_beats [$];
  pose_res_t expected_poses [$];
  beat_t cur;
  int gap = 0;
  int mismatches = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  // calculator state
  logic signed [31:0] bone_pos [256][3];
  logic signed [15:0] bone_quat [256][4];
  logic signed [31:0] node_pos [256][3];
  logic signed [15:0] node_quat [256][4];

  // generator bookkeeping
  bit bone_loaded [256];
  int written_nodes [$];
  bit node_written [256];

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint round_shift(longint x, int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (x < 0) return -((-x + half) >>> sh);
    return (x + half) >>> sh;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi, ref bit flag);
    if (x < lo) begin
      flag = 1'b1;
      return lo;
    end
    if (x > hi) begin
      flag = 1'b1;
      return hi;
    end
    return x;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  // returns 1 when the beat produces a pose result
  function automatic bit solve_pose(beat_t b, output pose_res_t r);
    longint lp [3], lq [4], pp [3], pq [4], gp [3], gq [4];
    longint u [3], t [3], c [3], c2 [3], m [4], un [4];
    longint w, s, num, mag, qv, rr;
    longint unsigned n2;
    bit has_bone, flag;
    int i;
    flag = 1'b0;
    w = 0;
    r = '0;
    if (b.op == sgp_pkg::OP_LOAD) begin
      for (i = 0; i < 3; i++) bone_pos[b.index][i] = b.p[i];
      for (i = 0; i < 4; i++) bone_quat[b.index][i] = b.q[i];
      return 1'b0;
    end
    has_bone = b.bone >= 0;
    if (b.parent < 0) begin
      for (i = 0; i < 3; i++) gp[i] = b.p[i];
      for (i = 0; i < 4; i++) gq[i] = b.q[i];
    end else begin
      for (i = 0; i < 3; i++) begin
        lp[i] = has_bone ? bone_pos[b.bone][i] : b.p[i];
        pp[i] = node_pos[b.parent][i];
        u[i] = 0;
      end
      for (i = 0; i < 4; i++) begin
        lq[i] = has_bone ? bone_quat[b.bone][i] : b.q[i];
        pq[i] = node_quat[b.parent][i];
      end
      n2 = 0;
      for (i = 0; i < 4; i++) n2 += longint'(pq[i] * pq[i]);
      if (n2 != 0) begin
        s = int_sqrt(n2 << 30);
        for (i = 0; i < 4; i++) begin
          num = pq[i] * (longint'(1) << 43);
          mag = num < 0 ? -num : num;
          qv = (mag + s / 2) / s;
          un[i] = num < 0 ? -qv : qv;
        end
        w = un[0];
        for (i = 0; i < 3; i++) u[i] = un[i + 1];
      end
      c[0] = u[1] * lp[2] - u[2] * lp[1];
      c[1] = u[2] * lp[0] - u[0] * lp[2];
      c[2] = u[0] * lp[1] - u[1] * lp[0];
      for (i = 0; i < 3; i++) t[i] = round_shift(2 * c[i], 28);
      c2[0] = u[1] * t[2] - u[2] * t[1];
      c2[1] = u[2] * t[0] - u[0] * t[2];
      c2[2] = u[0] * t[1] - u[1] * t[0];
      for (i = 0; i < 3; i++) begin
        rr = lp[i] + round_shift(w * t[i], 28) + round_shift(c2[i], 28) + pp[i];
        gp[i] = clip(rr, -64'sd2147483648, 64'sd2147483647, flag);
      end
      m[0] = pq[0]*lq[0] - pq[1]*lq[1] - pq[2]*lq[2] - pq[3]*lq[3];
      m[1] = pq[0]*lq[1] + pq[1]*lq[0] + pq[2]*lq[3] - pq[3]*lq[2];
      m[2] = pq[0]*lq[2] - pq[1]*lq[3] + pq[2]*lq[0] + pq[3]*lq[1];
      m[3] = pq[0]*lq[3] + pq[1]*lq[2] - pq[2]*lq[1] + pq[3]*lq[0];
      for (i = 0; i < 4; i++) gq[i] = clip(round_shift(m[i], 14), -32768, 32767, flag);
    end
    for (i = 0; i < 3; i++) node_pos[b.index][i] = gp[i][31:0];
    for (i = 0; i < 4; i++) node_quat[b.index][i] = gq[i][15:0];
    if (!has_bone) return 1'b0;
    r.bone = b.bone[7:0];
    r.pose = '{gp[0][31:0], gp[1][31:0], gp[2][31:0],
               gq[0][15:0], gq[1][15:0], gq[2][15:0], gq[3][15:0]};
    r.sat = flag;
    return 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    pose_res_t r;
    bit take;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        if (solve_pose(cur, r)) expected_poses.push_back(r);
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
      end
      if (!start || take) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          cur = pending_beats.pop_front();
          in_operation <= cur.op;
          in_index <= cur.index;
          in_parent_index <= cur.parent;
          in_bone_index <= cur.bone;
          in_pos_x <= cur.p[0];
          in_pos_y <= cur.p[1];
          in_pos_z <= cur.p[2];
          in_quat_w <= cur.q[0];
          in_quat_x <= cur.q[1];
          in_quat_y <= cur.q[2];
          in_quat_z <= cur.q[3];
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pose_res_t got, want;
    if (rst_n && out_valid) begin
      got.bone = out_bone;
      got.pose = '{out_global_x, out_global_y, out_global_z,
                   out_global_qw, out_global_qx, out_global_qy, out_global_qz};
      got.sat = out_saturated;
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose beat: bone %0d", out_bone);
      end else begin
        want = expected_poses.pop_front();
        if (got.bone !== want.bone || got.pose.x !== want.pose.x ||
            got.pose.y !== want.pose.y || got.pose.z !== want.pose.z ||
            got.pose.qw !== want.pose.qw || got.pose.qx !== want.pose.qx ||
            got.pose.qy !== want.pose.qy || got.pose.qz !== want.pose.qz ||
            got.sat !== want.sat) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pose mismatch bone %0d/%0d pos %0d %0d %0d / %0d %0d %0d",
                     want.bone, got.bone, want.pose.x, want.pose.y, want.pose.z,
                     got.pose.x, got.pose.y, got.pose.z);
            $display("  quat %0d %0d %0d %0d / %0d %0d %0d %0d sat %0b/%0b",
                     want.pose.qw, want.pose.qx, want.pose.qy, want.pose.qz,
                     got.pose.qw, got.pose.qx, got.pose.qy, got.pose.qz,
                     want.sat, got.sat);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_pos();
    case ($urandom_range(0, 6))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3, 4: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_quat();
    case ($urandom_range(0, 6))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      3, 4: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic beat_t make_beat(logic op, int index, int parent, int bone);
    beat_t b;
    int i;
    b.op = op;
    b.index = index[7:0];
    b.parent = parent[8:0];
    b.bone = bone[8:0];
    for (i = 0; i < 3; i++) b.p[i] = pick_pos();
    for (i = 0; i < 4; i++) b.q[i] = pick_quat();
    return b;
  endfunction

  task automatic queue_beat(beat_t b);
    if (b.op == sgp_pkg::OP_LOAD) begin
      bone_loaded[b.index] = 1'b1;
    end else if (!node_written[b.index]) begin
      node_written[b.index] = 1'b1;
      written_nodes.push_back(b.index);
    end
    pending_beats.push_back(b);
  endtask

  function automatic int pick_bone_for_child();
    int k;
    if ($urandom_range(0, 3) == 0) return -$urandom_range(1, 256);
    for (int n = 0; n < 8; n++) begin
      k = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 31);
      if (bone_loaded[k]) return k;
    end
    return -1;
  endfunction

  initial begin
    beat_t b;
    int idx, par, bn;
    // directed
    b = make_beat(sgp_pkg::OP_LOAD, 0, 0, 0);
    b.p = '{32'sh7fffffff, 32'sh80000000, 32'sd65536};
    b.q = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    queue_beat(b);
    b = make_beat(sgp_pkg::OP_LOAD, 255, 255, -256);
    b.q = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
    queue_beat(b);
    b = make_beat(sgp_pkg::OP_LOAD, 1, -1, 255);
    b.p = '{32'sd65536, 32'sd0, 32'sd0};
    b.q = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
    queue_beat(b);
    // root driving a bone keeps its rest pose
    b = make_beat(sgp_pkg::OP_NODE, 0, -1, 0);
    b.q = '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0};
    queue_beat(b);
    // most negative parent index is a root
    queue_beat(make_beat(sgp_pkg::OP_NODE, 255, -256, 200));
    queue_beat(make_beat(sgp_pkg::OP_NODE, 2, 0, 1));
    queue_beat(make_beat(sgp_pkg::OP_NODE, 3, 0, -1));
    queue_beat(make_beat(sgp_pkg::OP_NODE, 4, 255, -256));
    queue_beat(make_beat(sgp_pkg::OP_NODE, 5, 255, 255));
    // zero parent quaternion
    b = make_beat(sgp_pkg::OP_NODE, 6, -1, -1);
    b.q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
    queue_beat(b);
    queue_beat(make_beat(sgp_pkg::OP_NODE, 7, 6, 1));
    // position and quaternion clipping
    b = make_beat(sgp_pkg::OP_NODE, 8, -1, -1);
    b.p = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    b.q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    queue_beat(b);
    queue_beat(make_beat(sgp_pkg::OP_NODE, 9, 8, 0));
    b = make_beat(sgp_pkg::OP_NODE, 10, 8, -1);
    b.p = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    b.q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    queue_beat(b);
    // random hierarchies
    for (int n = 0; n < 2000; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          idx = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 31);
          queue_beat(make_beat(sgp_pkg::OP_LOAD, idx, -$urandom_range(1, 256),
                               $urandom_range(0, 255)));
        end
        5, 6, 7, 8: begin
          idx = $urandom_range(0, 4) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 63);
          par = $urandom_range(0, 2) == 0 ? -$urandom_range(1, 256) : -1;
          bn = $urandom_range(0, 2) == 0 ? -$urandom_range(1, 256) : $urandom_range(0, 255);
          queue_beat(make_beat(sgp_pkg::OP_NODE, idx, par, bn));
        end
        default: begin
          idx = $urandom_range(0, 4) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 63);
          par = written_nodes[$urandom_range(0, written_nodes.size() - 1)];
          queue_beat(make_beat(sgp_pkg::OP_NODE, idx, par, pick_bone_for_child()));
        end
      endcase
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_beats.size() < 150);
    quiet = 1'b1;
    wait (pending_beats.size() == 0 && !start);
    wait (expected_poses.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
